// ----- rtl/csma_rbc_pkg.sv -----
// Shared types, codes and a helper function for the CSMA retry and backoff controller.
// Used by csma_rbc_ctrl, csma_rbc_dp and csma_retry_backoff_controller; depends on nothing.
package csma_rbc_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_UNIT_PERIOD  = 2'd0,
		CFG_MIN_BE       = 2'd1,
		CFG_MAX_BE       = 2'd2,
		CFG_MAX_BACKOFFS = 2'd3
	} cfg_reg_t;

	// Request kinds.
	localparam logic KIND_SEND   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// Radio outcome codes carried by a report.
	localparam logic [2:0] TX_OK       = 3'd0;
	localparam logic [2:0] TX_NOACK    = 3'd1;
	localparam logic [2:0] TX_COLLIDED = 3'd2;
	localparam logic [2:0] TX_DEFERRED = 3'd3;

	// Result actions.
	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_SCHED = 2'd1;
	localparam logic [1:0] ACT_DONE  = 2'd2;

	// Final frame status codes.
	localparam logic [1:0] DS_OK    = 2'd0;
	localparam logic [1:0] DS_NOACK = 2'd1;
	localparam logic [1:0] DS_COLL  = 2'd2;
	localparam logic [1:0] DS_OTHER = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [15:0] RST_UNIT_PERIOD  = 16'd1;
	localparam logic [3:0]  RST_MIN_BE       = 4'd0;
	localparam logic [3:0]  RST_MAX_BE       = 4'd4;
	localparam logic [3:0]  RST_MAX_BACKOFFS = 4'd5;

	// Number of remainder steps, one per bit of the random value.
	localparam int unsigned DIV_STEPS = 16;

	typedef struct packed {
		logic        kind;
		logic [2:0]  status;
		logic [7:0]  tx_reported;
		logic [7:0]  tx_allowed;
		logic [15:0] random_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] delay;
		logic [1:0]  done_status;
		logic [7:0]  tx_count;
		logic [15:0] sequence_number;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} ctrl_state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load_in;
		logic update;
		logic mul;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic need_delay;
		logic div_last;
	} dp_sts_t;

	// Adds two counts and saturates at 255.
	function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

endpackage

// ----- rtl/csma_rbc_ctrl.sv -----
// Sequencing state machine of the CSMA retry and backoff controller.
// Depends on csma_rbc_pkg; drives the command struct of csma_rbc_dp.
module csma_rbc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  csma_rbc_pkg::dp_sts_t sts,
	output csma_rbc_pkg::dp_cmd_t cmd
);
	import csma_rbc_pkg::*;

	ctrl_state_t state_q, state_nxt;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_nxt = sts.need_delay ? ST_MUL : ST_OUT;
			end
			ST_MUL: begin
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_UPDATE: cmd.update   = 1'b1;
			ST_MUL:    cmd.mul      = 1'b1;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_OUT:    cmd.load_out = out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= cmd.load_out || (out_valid_q && !out_ready);
		end
	end

	// Only one request is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	// A result is never written over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("result register overwritten");

	// The remainder loop hands over to the output step after its last bit.
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && sts.div_last |=> state_q == ST_OUT)
		else $error("remainder loop did not finish");

endmodule

// ----- rtl/csma_rbc_dp.sv -----
// Datapath of the CSMA retry and backoff controller: configuration, frame state,
// window multiplier, bit-serial remainder unit and result register. Depends on csma_rbc_pkg.
module csma_rbc_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [15:0]             cfg_data,
	input  csma_rbc_pkg::in_item_t  in_data,
	input  csma_rbc_pkg::dp_cmd_t   cmd,
	output csma_rbc_pkg::dp_sts_t   sts,
	output csma_rbc_pkg::out_item_t out_data
);
	import csma_rbc_pkg::*;

	// Configuration.
	logic [15:0] period_q;
	logic [3:0]  min_be_q, max_be_q, max_bo_q;

	// Frame state.
	logic [8:0]  coll_q;
	logic [7:0]  tx_q;
	logic [7:0]  limit_q;
	logic [15:0] next_seq_q;
	logic        seeded_q;
	logic        active_q;

	// Request and working registers.
	in_item_t    in_q;
	logic [1:0]  act_q, dstat_q;
	logic [7:0]  txc_out_q;
	logic [15:0] seq_out_q;
	logic        need_delay_q;
	logic [3:0]  be_q;
	logic [30:0] window_q;
	logic [30:0] rem_q;
	logic [15:0] rnd_sh_q;
	logic [3:0]  step_q;
	out_item_t   out_q;

	// Next-state values of the update step.
	logic [8:0]  nxt_coll;
	logic [7:0]  nxt_tx, nxt_limit;
	logic [15:0] nxt_seq, seq_base;
	logic        nxt_seeded, nxt_active;
	logic [1:0]  u_act, u_dst;
	logic [7:0]  u_txc;
	logic [15:0] u_seq;
	logic        finish;
	logic [9:0]  coll_sum;
	logic [8:0]  coll_sat;
	logic [3:0]  be_nxt;
	logic [8:0]  min_be_ext;

	logic [14:0] be_mask;
	logic [15:0] unit;
	logic [31:0] rem_sh;
	logic        rem_ge;

	assign min_be_ext = {5'd0, min_be_q};
	assign coll_sum   = {1'b0, coll_q} + {2'b00, in_q.tx_reported};
	assign coll_sat   = coll_sum[9] ? 9'h1FF : coll_sum[8:0];

	always_comb begin
		nxt_coll   = coll_q;
		nxt_tx     = tx_q;
		nxt_limit  = limit_q;
		nxt_seq    = next_seq_q;
		nxt_seeded = seeded_q;
		nxt_active = active_q;
		u_act      = ACT_NONE;
		u_dst      = DS_OK;
		u_txc      = 8'd0;
		u_seq      = 16'd0;
		finish     = 1'b0;
		seq_base   = seeded_q ? next_seq_q : in_q.random_value;
		if (seq_base == 16'd0) seq_base = 16'd1;
		if (in_q.kind == KIND_SEND) begin
			u_seq      = seq_base;
			nxt_seq    = seq_base + 16'd1;
			nxt_seeded = 1'b1;
			nxt_tx     = 8'd0;
			nxt_coll   = min_be_ext;
			nxt_limit  = in_q.tx_allowed;
			nxt_active = 1'b1;
			u_act      = ACT_SCHED;
		end else if (active_q) begin
			case (in_q.status)
				TX_OK: begin
					nxt_coll = min_be_ext;
					nxt_tx   = sat_add8(tx_q, in_q.tx_reported);
					finish   = 1'b1;
					u_dst    = DS_OK;
				end
				TX_NOACK: begin
					nxt_coll = min_be_ext;
					nxt_tx   = sat_add8(tx_q, in_q.tx_reported);
					if (nxt_tx >= limit_q) begin
						finish = 1'b1;
						u_dst  = DS_NOACK;
					end
				end
				TX_COLLIDED: begin
					if (coll_sat > {5'd0, max_bo_q}) begin
						nxt_coll = min_be_ext;
						nxt_tx   = sat_add8(tx_q, 8'd1);
					end else begin
						nxt_coll = coll_sat;
					end
					if (nxt_tx >= limit_q) begin
						finish = 1'b1;
						u_dst  = DS_COLL;
					end
				end
				TX_DEFERRED: begin
					finish = 1'b0;
				end
				default: begin
					finish = 1'b1;
					u_dst  = DS_OTHER;
				end
			endcase
			if (finish) begin
				u_act      = ACT_DONE;
				u_txc      = nxt_tx;
				nxt_active = 1'b0;
			end else if (in_q.status == TX_NOACK || in_q.status == TX_COLLIDED) begin
				u_act = ACT_SCHED;
			end
		end
		if (u_act != ACT_DONE) u_dst = DS_OK;
	end

	assign be_nxt = (nxt_coll > {5'd0, max_be_q}) ? max_be_q : nxt_coll[3:0];

	assign sts.need_delay = (u_act == ACT_SCHED);
	assign sts.div_last   = (step_q == 4'(DIV_STEPS - 1));

	assign be_mask = 15'((17'd1 << be_q) - 17'd1);
	assign unit    = (period_q == 16'd0) ? 16'd1 : period_q;
	assign rem_sh  = {rem_q, rnd_sh_q[15]};
	assign rem_ge  = rem_sh >= {1'b0, window_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= RST_UNIT_PERIOD;
			min_be_q   <= RST_MIN_BE;
			max_be_q   <= RST_MAX_BE;
			max_bo_q   <= RST_MAX_BACKOFFS;
			coll_q     <= 9'd0;
			tx_q       <= 8'd0;
			limit_q    <= 8'd1;
			next_seq_q <= 16'd0;
			seeded_q   <= 1'b0;
			active_q   <= 1'b0;
			step_q     <= 4'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_UNIT_PERIOD:  period_q <= cfg_data;
					CFG_MIN_BE:       min_be_q <= cfg_data[3:0];
					CFG_MAX_BE:       max_be_q <= cfg_data[3:0];
					CFG_MAX_BACKOFFS: max_bo_q <= cfg_data[3:0];
					default:          period_q <= period_q;
				endcase
			end
			if (cmd.update) begin
				coll_q     <= nxt_coll;
				tx_q       <= nxt_tx;
				limit_q    <= nxt_limit;
				next_seq_q <= nxt_seq;
				seeded_q   <= nxt_seeded;
				active_q   <= nxt_active;
			end
			if (cmd.mul) begin
				step_q <= 4'd0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) in_q <= in_data;
		if (cmd.update) begin
			act_q        <= u_act;
			dstat_q      <= u_dst;
			txc_out_q    <= u_txc;
			seq_out_q    <= u_seq;
			need_delay_q <= (u_act == ACT_SCHED);
			be_q         <= be_nxt;
		end
		if (cmd.mul) begin
			window_q <= {16'd0, be_mask} * {15'd0, unit};
			rem_q    <= 31'd0;
			rnd_sh_q <= in_q.random_value;
		end else if (cmd.div_step) begin
			rem_q    <= rem_ge ? 31'(rem_sh - {1'b0, window_q}) : rem_sh[30:0];
			rnd_sh_q <= {rnd_sh_q[14:0], 1'b0};
		end
		if (cmd.load_out) begin
			out_q.action          <= act_q;
			out_q.delay           <= (need_delay_q && window_q != 31'd0) ? rem_q[15:0] : 16'd0;
			out_q.done_status     <= dstat_q;
			out_q.tx_count        <= txc_out_q;
			out_q.sequence_number <= seq_out_q;
		end
	end

	assign out_data = out_q;

	// A new frame is always active afterwards and never carries sequence number zero.
	a_send_starts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && in_q.kind == KIND_SEND |=> active_q && seq_out_q != 16'd0)
		else $error("send did not start a numbered frame");

	// A finished frame leaves no active frame behind.
	a_done_clears_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && u_act == ACT_DONE |=> !active_q)
		else $error("finished frame still active");

	// A report that finds no open frame leaves nothing to do.
	a_idle_report: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && in_q.kind == KIND_REPORT && !active_q |=> act_q == ACT_NONE)
		else $error("report without a frame produced an action");

endmodule

// ----- rtl/csma_retry_backoff_controller.sv -----
// Top level of the CSMA retry and backoff controller.
// Depends on csma_rbc_pkg, csma_rbc_ctrl and csma_rbc_dp.
//
// This block tracks the retry state of one outgoing frame. A send request
// starts a frame: it gets a nonzero sequence number (seeded from the random
// value on the very first send), the transmission count is cleared, the
// collision count is set to the minimum BE and the first transmission is
// scheduled after a random backoff. A report request applies the radio outcome
// and yields a finished frame with its final status and transmission count, a
// retry scheduled after a random delay of random_value mod ((2^BE - 1) * P),
// P being the configured unit period and BE the collision count clamped to
// max_backoff_exponent, or no action (deferred outcome or no open frame).
// Every request gives exactly one result. A request needing a delay passes
// the update step, window multiply and 16-step bit-serial remainder unit (one
// bit of the random value per cycle) before the output step; one needing no
// delay goes from update straight to output. One request is processed at a
// time; in_ready is high whenever the engine is idle, even while an earlier
// result still waits in the output register. Configuration writes take effect
// at once and should only be made while no request is in flight.
module csma_retry_backoff_controller (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  csma_rbc_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output csma_rbc_pkg::out_item_t out_data,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [15:0]             cfg_data
);
	import csma_rbc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// The controller sequences update, multiply, remainder and output steps.
	csma_rbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds configuration, frame state and the result register.
	csma_rbc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule
